>>> rtl/core/brq_pkg.sv
package brq_pkg;

  localparam int unsigned CNT_W  = 7;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned CTR_W  = 32;

  // action codes
  localparam logic [2:0] ACT_PUT   = 3'd0;
  localparam logic [2:0] ACT_GET   = 3'd1;
  localparam logic [2:0] ACT_PEEK  = 3'd2;
  localparam logic [2:0] ACT_SKIP  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  // result status codes
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_NONE = 2'd1;
  localparam logic [1:0] STS_REJ  = 2'd2;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [WORD_W-1:0] data_in;
    logic [CNT_W-1:0]        count;
    logic [CTR_W-1:0]        head_token;
    logic                    batch_first;
    logic                    batch_last;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [CNT_W-1:0]        moved;
    logic [CTR_W-1:0]        head_seen;
    logic [1:0]              status;
    logic                    last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic exec_single;   // execute accepted word, load its single result
    logic start_stream;  // latch get/peek read job
    logic issue;         // RAM read of next element
    logic load_elem;     // move RAM read data to output register
    logic finish;        // close read job, retire head for get
  } brq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic stream_go;     // incoming word is a get/peek with elements to read
    logic more;          // reads still to issue
    logic emit_last;     // element being emitted is the final one
  } brq_sts_t;

endpackage

>>> rtl/core/batch_ring_queue_with_peek_skip.sv
// Ring FIFO of signed 64-bit words, DEPTH entries (power of two, 2..64), with
// free-running 32-bit head and tail counters; fill = tail - head. Each input
// word carries one action. Put writes one element; a batch opens on
// batch_first (its count is the batch length, checked against free space,
// all or nothing) and commits on batch_last by advancing tail. Get and peek
// return min(count, fill) result words, the final one marked last; get then
// advances head, peek also reports the head value it read from. Skip advances
// head by count when count fits the fill and head_token matches head. Clear
// zeroes both counters and drops any open batch. Every other action, and get
// or peek with nothing to read, answers with one word. Timing: a new word is
// taken each cycle as long as the output register drains. Get and peek latch
// the job on accept, then make the first registered read of the single-port
// ring RAM, then emit one element per cycle while the output register drains,
// with the next read prefetched one element ahead; input is held off until
// the last element is loaded. Output backpressure stalls the stream without
// losing elements. The ring RAM has no reset; head/tail discipline keeps
// reads on written entries.
module batch_ring_queue_with_peek_skip import brq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  brq_cmd_t cmd;
  brq_sts_t sts;

  // sequencing: accept, stream reads, output register occupancy
  brq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // counters, batch state, ring RAM and output word
  brq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule

>>> rtl/core/brq_ram.sv
module brq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/brq_dpath.sv
module brq_dpath import brq_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  in_word_i,
  input  brq_cmd_t  cmd_i,
  output brq_sts_t  sts_o,
  output out_word_t out_word_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CTR_W-1:0] head_q, head_d, tail_q, tail_d;
  logic             bacc_q, bacc_d;
  logic [CNT_W-1:0] bidx_q, bidx_d, blen_q, blen_d;
  logic [CNT_W-1:0] n_q, n_d, iss_q, iss_d, emt_q, emt_d;
  logic [CTR_W-1:0] hsnap_q, hsnap_d;
  logic             peek_q, peek_d;
  out_word_t        out_q, out_d;

  logic [CTR_W-1:0] diff;
  logic [CNT_W-1:0] fill, room, n_rd;
  logic             eff_acc, do_write, skip_ok, is_rd;
  logic [CNT_W-1:0] eff_idx, eff_len, idx_inc, new_idx;
  logic [AW-1:0]    waddr, raddr;
  logic [WORD_W-1:0] rdata;
  out_word_t        single;

  always_comb begin
    diff = tail_q - head_q;
    fill = (diff > CTR_W'(DEPTH)) ? CNT_W'(DEPTH) : diff[CNT_W-1:0];
    room = CNT_W'(DEPTH) - fill;
    n_rd = (in_word_i.count < fill) ? in_word_i.count : fill;
    is_rd = in_word_i.action inside {ACT_GET, ACT_PEEK};

    // put: batch open state, or a fresh one on the first element
    eff_acc  = in_word_i.batch_first ? (in_word_i.count <= room) : bacc_q;
    eff_idx  = in_word_i.batch_first ? '0 : bidx_q;
    eff_len  = in_word_i.batch_first ? in_word_i.count : blen_q;
    do_write = eff_acc && (eff_idx < eff_len);
    idx_inc  = eff_idx + CNT_W'(1);
    new_idx  = do_write ? idx_inc : eff_idx;

    skip_ok = (in_word_i.count != '0) && (in_word_i.count <= fill) &&
              (in_word_i.head_token == head_q);

    waddr = tail_q[AW-1:0] + eff_idx[AW-1:0];
    raddr = hsnap_q[AW-1:0] + iss_q[AW-1:0];
  end

  // single-result word for everything that is not a streamed read
  always_comb begin
    single = '{data_out: '0, moved: '0, head_seen: '0, status: STS_NONE, last: 1'b1};
    head_d = head_q;
    tail_d = tail_q;
    bacc_d = bacc_q;
    bidx_d = bidx_q;
    blen_d = blen_q;
    case (in_word_i.action)
      ACT_PUT: begin
        single.status = !eff_acc ? STS_REJ : (do_write ? STS_OK : STS_NONE);
        single.moved  = do_write ? idx_inc : '0;
        if (in_word_i.batch_last) begin
          tail_d = eff_acc ? tail_q + CTR_W'(new_idx) : tail_q;
          bacc_d = 1'b0;
          bidx_d = '0;
          blen_d = '0;
        end else begin
          bacc_d = eff_acc;
          bidx_d = new_idx;
          blen_d = eff_len;
        end
      end
      ACT_PEEK: begin
        single.head_seen = head_q;
      end
      ACT_SKIP: begin
        if (skip_ok) begin
          single.status = STS_OK;
          single.moved  = in_word_i.count;
          head_d        = head_q + CTR_W'(in_word_i.count);
        end
      end
      ACT_CLEAR: begin
        head_d = '0;
        tail_d = '0;
        bacc_d = 1'b0;
        bidx_d = '0;
        blen_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    n_d     = n_q;
    iss_d   = iss_q;
    emt_d   = emt_q;
    hsnap_d = hsnap_q;
    peek_d  = peek_q;
    out_d   = out_q;
    if (cmd_i.start_stream) begin
      n_d     = n_rd;
      iss_d   = '0;
      emt_d   = '0;
      hsnap_d = head_q;
      peek_d  = (in_word_i.action == ACT_PEEK);
    end
    if (cmd_i.issue) begin
      iss_d = iss_q + CNT_W'(1);
    end
    if (cmd_i.exec_single) begin
      out_d = single;
    end else if (cmd_i.load_elem) begin
      out_d.data_out  = rdata;
      out_d.moved     = n_q;
      out_d.head_seen = peek_q ? hsnap_q : '0;
      out_d.status    = STS_OK;
      out_d.last      = sts_o.emit_last;
      emt_d           = emt_q + CNT_W'(1);
    end
  end

  assign sts_o.stream_go = is_rd && (n_rd != '0);
  assign sts_o.more      = (iss_q != n_q);
  assign sts_o.emit_last = (emt_q == n_q - CNT_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      bacc_q <= 1'b0;
      bidx_q <= '0;
      blen_q <= '0;
      n_q    <= '0;
      iss_q  <= '0;
      emt_q  <= '0;
      peek_q <= 1'b0;
    end else begin
      if (cmd_i.exec_single) begin
        head_q <= head_d;
        tail_q <= tail_d;
        bacc_q <= bacc_d;
        bidx_q <= bidx_d;
        blen_q <= blen_d;
      end else if (cmd_i.finish && !peek_q) begin
        head_q <= hsnap_q + CTR_W'(n_q);
      end
      n_q    <= n_d;
      iss_q  <= iss_d;
      emt_q  <= emt_d;
      peek_q <= peek_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hsnap_q <= hsnap_d;
    out_q   <= out_d;
  end

  brq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.exec_single && (in_word_i.action == ACT_PUT) && do_write),
    .re_i    (cmd_i.issue),
    .addr_i  (cmd_i.issue ? raddr : waddr),
    .wdata_i (in_word_i.data_in),
    .rdata_o (rdata)
  );

  assign out_word_o = out_q;

endmodule

>>> rtl/core/brq_ctrl.sv
module brq_ctrl import brq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  brq_sts_t sts_i,
  output brq_cmd_t cmd_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  logic state_q, state_d;
  logic rdv_q, rdv_d;     // RAM read register holds an unsent element
  logic ovld_q, ovld_d;   // output register full
  logic ob_free, load;

  always_comb begin
    ob_free    = !ovld_q || out_ready_i;
    load       = 1'b0;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    state_d    = state_q;
    rdv_d      = rdv_q;
    ovld_d     = ovld_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = ob_free;
        if (in_valid_i && ob_free) begin
          if (sts_i.stream_go) begin
            cmd_o.start_stream = 1'b1;
            rdv_d              = 1'b0;
            state_d            = ST_STREAM;
          end else begin
            cmd_o.exec_single = 1'b1;
            ovld_d            = 1'b1;
          end
        end
      end
      ST_STREAM: begin
        load            = rdv_q && ob_free;
        cmd_o.load_elem = load;
        cmd_o.issue     = sts_i.more && (!rdv_q || load);
        rdv_d           = cmd_o.issue ? 1'b1 : (load ? 1'b0 : rdv_q);
        if (load) begin
          ovld_d = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rdv_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= rdv_d;
      ovld_q  <= ovld_d;
    end
  end

  assign out_valid_o = ovld_q;

endmodule

>>> rtl/core/brq_checker.sv
module brq_checker import brq_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_word_t  in_word_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.status == STS_OK) || (out_word_o.status == STS_NONE) ||
                    (out_word_o.status == STS_REJ))
    else $error("undefined status code");

  // only ok results can be part of a multi-word answer
  a_nonok_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != STS_OK) |-> out_word_o.last)
    else $error("failed result not marked last");

  a_nonok_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status != STS_OK) |->
      (out_word_o.moved == '0) && (out_word_o.data_out == '0))
    else $error("failed result carries data");

endmodule

bind batch_ring_queue_with_peek_skip brq_checker u_brq_checker (.*);

>>> tb/tb_batch_ring_queue_with_peek_skip.sv
module tb_batch_ring_queue_with_peek_skip;
  timeunit 1ns;
  timeprecision 1ps;

  import brq_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned CNT_MAX      = (1 << CNT_W) - 1;
  localparam int unsigned RANDOM_WORDS = 165;
  // Longest legal quiet stretch is a long sender gap plus a long receiver
  // stall plus the pipeline delay; this is many times that.
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 20;

  // action codes the block does not define; it must answer them as no-ops
  localparam logic [2:0] ACT_RSVD5 = 3'd5;
  localparam logic [2:0] ACT_RSVD6 = 3'd6;
  localparam logic [2:0] ACT_RSVD7 = 3'd7;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  always #6 clk_i = ~clk_i;

  batch_ring_queue_with_peek_skip #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  // ---------------------------------------------------------------------
  // Mirror of the queue: ring contents, free-running counters, and the
  // state of the put batch being collected.
  // ---------------------------------------------------------------------
  logic signed [WORD_W-1:0] ring_mirror [DEPTH];
  logic [CTR_W-1:0]         head_mirror   = '0;
  logic [CTR_W-1:0]         tail_mirror   = '0;
  logic                     batch_ok      = 1'b0;
  int unsigned              batch_pos     = 0;
  int unsigned              batch_len     = 0;

  out_word_t   resp_due_q[$];   // response words owed by the block, oldest first
  int unsigned mismatches   = 0;
  int unsigned words_sent   = 0;
  bit          idling       = 1'b1;  // random gaps/stalls on or off
  int unsigned rx_stall     = 0;
  int unsigned quiet_cycles = 0;

  // fill = tail - head, modulo 2^32, never above DEPTH
  function automatic int unsigned ring_fill();
    logic [CTR_W-1:0] diff;
    diff = tail_mirror - head_mirror;
    return (diff > DEPTH) ? DEPTH : diff;
  endfunction

  // Apply one accepted word to the mirror and queue the responses it owes.
  function automatic void compute_queue_responses(input in_word_t w);
    out_word_t        r;
    int unsigned      n;
    logic [CTR_W-1:0] h;
    r        = '0;
    r.status = STS_NONE;
    r.last   = 1'b1;
    case (w.action)
      ACT_PUT: begin
        // first word carries the batch length; all or nothing vs free space
        if (w.batch_first) begin
          batch_len = w.count;
          batch_pos = 0;
          batch_ok  = (w.count <= DEPTH - ring_fill());
        end
        if (!batch_ok) begin
          r.status = STS_REJ;
        end else if (batch_pos < batch_len) begin
          ring_mirror[(tail_mirror + batch_pos) & (DEPTH - 1)] = w.data_in;
          batch_pos++;
          r.moved  = CNT_W'(batch_pos);
          r.status = STS_OK;
        end
        // words past the declared length fall through as STS_NONE
        if (w.batch_last) begin
          if (batch_ok) tail_mirror += batch_pos;
          batch_ok  = 1'b0;
          batch_pos = 0;
          batch_len = 0;
        end
      end
      ACT_GET, ACT_PEEK: begin
        n = (w.count < ring_fill()) ? w.count : ring_fill();
        h = head_mirror;
        if (w.action == ACT_PEEK) r.head_seen = h;
        if (n != 0) begin
          r.status = STS_OK;
          r.moved  = CNT_W'(n);
          for (int unsigned i = 0; i < n; i++) begin
            r.data_out = ring_mirror[(h + i) & (DEPTH - 1)];
            r.last     = (i == n - 1);
            resp_due_q.push_back(r);
          end
          if (w.action == ACT_GET) head_mirror = h + n;
          return;
        end
      end
      ACT_SKIP: begin
        if (w.count != 0 && w.count <= ring_fill() && w.head_token == head_mirror) begin
          head_mirror += w.count;
          r.moved  = w.count;
          r.status = STS_OK;
        end
      end
      ACT_CLEAR: begin
        head_mirror = '0;
        tail_mirror = '0;
        batch_ok    = 1'b0;
        batch_pos   = 0;
        batch_len   = 0;
      end
      default: ;
    endcase
    resp_due_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idling) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_count();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, CNT_MAX) : $urandom_range(1, 8);
  endfunction

  // fields the action does not use are random so every bit toggles
  function automatic in_word_t op_word(input logic [2:0] act, input int unsigned cnt,
                                       input logic [CTR_W-1:0] token);
    in_word_t w;
    w.action      = act;
    w.data_in     = {$urandom, $urandom};
    w.count       = CNT_W'(cnt);
    w.head_token  = token;
    w.batch_first = 1'($urandom_range(0, 1));
    w.batch_last  = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // Present one word and hold it until accepted. Called at a rising edge;
  // valid is only lowered when a gap follows, so it never toggles twice
  // in one step.
  task automatic push_word(input in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    compute_queue_responses(w);
    words_sent++;
  endtask

  // declared: length on the first word; sent: words pushed; closes: last
  // word carries batch_last
  task automatic send_batch(input int unsigned declared, input int unsigned sent,
                            input bit closes);
    in_word_t w;
    for (int unsigned i = 0; i < sent; i++) begin
      w = op_word(ACT_PUT, (i == 0) ? declared : $urandom_range(0, CNT_MAX), $urandom);
      w.batch_first = (i == 0);
      w.batch_last  = closes && (i == sent - 1);
      push_word(w);
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  task automatic test_directed_cases();
    in_word_t w;
    push_word(op_word(ACT_GET, 5, $urandom));       // empty ring
    push_word(op_word(ACT_PEEK, 0, $urandom));
    // put with no batch open
    w = op_word(ACT_PUT, 9, $urandom);
    w.batch_first = 1'b0;
    w.batch_last  = 1'b0;
    push_word(w);
    // three-word batch at the data extremes
    w = op_word(ACT_PUT, 3, $urandom);
    w.batch_first = 1'b1;
    w.batch_last  = 1'b0;
    w.data_in     = {1'b0, {(WORD_W-1){1'b1}}};
    push_word(w);
    w.batch_first = 1'b0;
    w.data_in     = {1'b1, {(WORD_W-1){1'b0}}};
    push_word(w);
    w.batch_last  = 1'b1;
    w.data_in     = '1;
    push_word(w);
    push_word(op_word(ACT_PEEK, CNT_MAX, $urandom));      // count above fill
    push_word(op_word(ACT_SKIP, 1, head_mirror + 1'b1));  // stale token
    push_word(op_word(ACT_SKIP, 0, head_mirror));         // zero count
    push_word(op_word(ACT_SKIP, 1, head_mirror));
    push_word(op_word(ACT_GET, 1, $urandom));
    send_batch(1, 2, 1'b1);        // second word beyond the length
    send_batch(5, 2, 1'b1);        // short batch commits two
    send_batch(4, 2, 1'b0);        // left open ...
    send_batch(2, 2, 1'b1);        // ... abandoned by a new first
    send_batch(CNT_MAX, 2, 1'b1);  // too large, rejected through its last word
    push_word(op_word(ACT_PEEK, DEPTH, $urandom));
    push_word(op_word(ACT_CLEAR, 0, $urandom));
    push_word(op_word(ACT_RSVD5, 3, $urandom));
    push_word(op_word(ACT_RSVD6, 3, $urandom));
    push_word(op_word(ACT_RSVD7, 3, $urandom));
    push_word(op_word(ACT_GET, DEPTH, $urandom));   // counters back at zero
  endtask

  // Fill every entry, then poke at the full ring.
  task automatic test_full_ring();
    send_batch(DEPTH, DEPTH, 1'b1);
    send_batch(1, 1, 1'b1);   // no room
    send_batch(0, 1, 1'b1);   // zero-length batch still fits
    push_word(op_word(ACT_PEEK, DEPTH, $urandom));
    push_word(op_word(ACT_SKIP, DEPTH, ~head_mirror));
    push_word(op_word(ACT_GET, CNT_MAX, $urandom));
  endtask

  // Mostly well-formed batches and reads, with broken batches and noise.
  task automatic test_random_traffic();
    in_word_t    w;
    int unsigned stop_at;
    int unsigned roll;
    int unsigned len;
    stop_at = words_sent + RANDOM_WORDS;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) idling = ~idling;
      roll = $urandom_range(0, 99);
      if (roll < 38) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        send_batch(len, len, 1'b1);
      end else if (roll < 56) begin
        push_word(op_word(ACT_GET, pick_count(), $urandom));
      end else if (roll < 68) begin
        push_word(op_word(ACT_PEEK, pick_count(), $urandom));
      end else if (roll < 80) begin
        if ($urandom_range(0, 3) != 0)
          push_word(op_word(ACT_SKIP, $urandom_range(0, ring_fill() + 1), head_mirror));
        else
          push_word(op_word(ACT_SKIP, $urandom_range(0, CNT_MAX), $urandom));
      end else if (roll < 90) begin
        len = $urandom_range(1, 8);
        case ($urandom_range(0, 3))
          0: send_batch(len + 2, $urandom_range(1, 2), 1'b1);     // closed early
          1: send_batch(len, len + $urandom_range(1, 2), 1'b1);   // overlong
          2: send_batch(len, $urandom_range(1, 3), 1'b0);         // left open
          default: begin                                          // stray put
            w = op_word(ACT_PUT, pick_count(), $urandom);
            w.batch_first = 1'b0;
            push_word(w);
          end
        endcase
      end else if (roll < 93) begin
        push_word(op_word(ACT_CLEAR, pick_count(), $urandom));
      end else if (roll < 96) begin
        push_word(op_word(ACT_RSVD5 + 3'($urandom_range(0, 2)), pick_count(), $urandom));
      end else begin
        push_word(op_word(3'($urandom_range(0, 7)), $urandom_range(0, CNT_MAX), $urandom));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("[%0t] MISMATCH %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] got,
                             input logic [WORD_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h, want %h", name, got, want));
  endtask

  task automatic check_response(input out_word_t got);
    out_word_t want;
    if (resp_due_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word %h", got));
      return;
    end
    want = resp_due_q.pop_front();
    check_field("data_out",  got.data_out,  want.data_out);
    check_field("moved",     got.moved,     want.moved);
    check_field("head_seen", got.head_seen, want.head_seen);
    check_field("status",    got.status,    want.status);
    check_field("last",      got.last,      want.last);
  endtask

  // Receiver: check at the accepting edge, then pick the next ready.
  // Stalls are mostly short, with a few much longer ones.
  always @(posedge clk_i) begin : rx_side
    int unsigned roll;
    if (rst_ni) begin
      if (out_valid && out_ready) check_response(out_word);
      if (rx_stall != 0) begin
        rx_stall  <= rx_stall - 1;
        out_ready <= 1'b0;
      end else if (!idling) begin
        out_ready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 65) begin
          out_ready <= 1'b1;
        end else if (roll < 93) begin
          out_ready <= 1'b0;
          rx_stall  <= $urandom_range(0, 2);
        end else begin
          out_ready <= 1'b0;
          rx_stall  <= $urandom_range(9, 39);
        end
      end
    end
  end

  // Watchdog: too long without a handshake on either side means a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_full_ring();
    test_random_traffic();
    in_valid <= 1'b0;
    // drain, then give stray words a chance to show up
    while (resp_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/brq_pkg.sv
rtl/core/brq_ram.sv
rtl/core/brq_dpath.sv
rtl/core/brq_ctrl.sv
rtl/core/batch_ring_queue_with_peek_skip.sv
rtl/core/brq_checker.sv
tb/tb_batch_ring_queue_with_peek_skip.sv
